// ----- hw/rtl/tvbb_pkg.sv -----
// Shared types and constants for the transformed vertex bounding box block.
package tvbb_pkg;

   localparam int COORD_W   = 16;
   localparam int INDEX_W   = 8;
   localparam int ROW_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int FRAC_DROP = 12;
   localparam int LANES     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z = 2'd2;

   localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

   // The homogeneous one enters the product as 1.0 in Q8.8.
   localparam logic signed [COORD_W-1:0] ONE_Q8_8 = 16'sd256;
   localparam logic signed [ACC_W:0]     ROUND_BIAS = 35'sd2048;
   localparam logic signed [ACC_W-FRAC_DROP:0] SAT_HIGH = 23'sd32767;
   localparam logic signed [ACC_W-FRAC_DROP:0] SAT_LOW  = -23'sd32768;

   localparam logic [2:0] MAC_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_NORM,
      ST_READ,
      ST_FOLD
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_lane;
      logic       acc_en;
      logic       acc_first;
      logic       store_en;
      logic       read_en;
      logic       fold_en;
   } cmd_type;

endpackage

// ----- hw/rtl/tvbb_ctrl.sv -----
// Sequencer that steps the datapath through transform and fold operations.
module tvbb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_kind,
   output logic              busy,
   output tvbb_pkg::cmd_type cmd
);
   import tvbb_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            count_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = req_kind ? ST_READ : ST_MUL;
            end
         end
         ST_MUL: begin
            // Products are registered, so each product is accumulated in the step after its multiply.
            cmd.mul_en    = (count_ff != MAC_LAST);
            cmd.mul_lane  = count_ff[1:0];
            cmd.acc_en    = (count_ff != 3'd0);
            cmd.acc_first = (count_ff == 3'd1);
            count_in      = count_ff + 3'd1;
            if (count_ff == MAC_LAST) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.store_en = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold_en = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/tvbb_dpath.sv -----
// Datapath: matrix rows, shared multipliers, vertex store and running box.
module tvbb_dpath #(
   parameter int VERTEX_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tvbb_pkg::cmd_type                      cmd,
   input  logic signed [tvbb_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [tvbb_pkg::COORD_W-1:0]    req_coord_y,
   input  logic signed [tvbb_pkg::COORD_W-1:0]    req_coord_z,
   input  logic [tvbb_pkg::INDEX_W-1:0]           req_vertex_index,
   input  logic                                   req_last,
   input  logic                                   csr_write_enable,
   input  logic [tvbb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tvbb_pkg::ROW_W-1:0]             csr_write_data,
   output logic                                   rsp_valid,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_min_x,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_max_x,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_min_y,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_max_y,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_min_z,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_max_z,
   output logic                                   rsp_saturated
);
   import tvbb_pkg::*;

   localparam int ADDR_W     = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int MAP_DEPTH  = 2 ** INDEX_W;
   localparam int Q_W        = ACC_W - FRAC_DROP + 1;
   localparam int ENTRY_W    = 3 * COORD_W;

   // Index reduction modulo the store depth as a constant lookup.
   logic [ADDR_W-1:0] index_map [MAP_DEPTH];
   for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_map
      assign index_map[g] = ADDR_W'(g % VERTEX_DEPTH);
   end

   logic [ROW_W-1:0]          coef_ff [3];
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic                      last_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [ADDR_W-1:0]         wp_ff;
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic [ENTRY_W-1:0]        store_mem [VERTEX_DEPTH];
   logic [ENTRY_W-1:0]        rd_ff;
   logic signed [COORD_W-1:0] lo_ff [3];
   logic signed [COORD_W-1:0] hi_ff [3];
   logic                      started_ff;
   logic                      clip_ff;

   logic signed [COORD_W-1:0] operand;
   logic signed [COORD_W-1:0] coef_lane [3];
   logic signed [ACC_W:0]     biased [3];
   logic signed [Q_W-1:0]     quot [3];
   logic signed [COORD_W-1:0] sat [3];
   logic [2:0]                clip_any;
   logic signed [COORD_W-1:0] vtx [3];
   logic signed [COORD_W-1:0] lo_in [3];
   logic signed [COORD_W-1:0] hi_in [3];
   logic [ADDR_W-1:0]         wp_in;

   always_comb begin
      case (cmd.mul_lane)
         2'd0:    operand = x_ff;
         2'd1:    operand = y_ff;
         2'd2:    operand = z_ff;
         default: operand = ONE_Q8_8;
      endcase
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coef_lane[r] = $signed(coef_ff[r][COORD_W*cmd.mul_lane +: COORD_W]);
         // Round half up to Q8.8, then clip to the 16-bit range.
         biased[r]    = $signed({acc_ff[r][ACC_W-1], acc_ff[r]}) + ROUND_BIAS;
         quot[r]      = Q_W'(biased[r] >>> FRAC_DROP);
         clip_any[r]  = 1'b0;
         if (quot[r] > SAT_HIGH) begin
            sat[r]      = SAT_HIGH[COORD_W-1:0];
            clip_any[r] = 1'b1;
         end else if (quot[r] < SAT_LOW) begin
            sat[r]      = SAT_LOW[COORD_W-1:0];
            clip_any[r] = 1'b1;
         end else begin
            sat[r] = quot[r][COORD_W-1:0];
         end
         vtx[r] = $signed(rd_ff[COORD_W*r +: COORD_W]);
         // The first index of a run seeds both bounds.
         if (!started_ff) begin
            lo_in[r] = vtx[r];
            hi_in[r] = vtx[r];
         end else begin
            lo_in[r] = (vtx[r] < lo_ff[r]) ? vtx[r] : lo_ff[r];
            hi_in[r] = (vtx[r] > hi_ff[r]) ? vtx[r] : hi_ff[r];
         end
      end
   end

   always_comb begin
      if (last_ff || (wp_ff == ADDR_W'(VERTEX_DEPTH - 1))) begin
         wp_in = '0;
      end else begin
         wp_in = wp_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= ROW_X_RESET;
         coef_ff[1] <= ROW_Y_RESET;
         coef_ff[2] <= ROW_Z_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_X: coef_ff[0] <= csr_write_data;
            CSR_ROW_Y: coef_ff[1] <= csr_write_data;
            CSR_ROW_Z: coef_ff[2] <= csr_write_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_coord_x;
         y_ff    <= req_coord_y;
         z_ff    <= req_coord_z;
         last_ff <= req_last;
         addr_ff <= index_map[req_vertex_index];
      end
      for (int r = 0; r < 3; r++) begin
         if (cmd.mul_en) begin
            prod_ff[r] <= operand * coef_lane[r];
         end
         if (cmd.acc_en) begin
            if (cmd.acc_first) begin
               acc_ff[r] <= ACC_W'(prod_ff[r]);
            end else begin
               acc_ff[r] <= acc_ff[r] + ACC_W'(prod_ff[r]);
            end
         end
         if (cmd.fold_en) begin
            lo_ff[r] <= lo_in[r];
            hi_ff[r] <= hi_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_en) begin
         store_mem[wp_ff] <= {sat[2], sat[1], sat[0]};
      end
      if (cmd.read_en) begin
         rd_ff <= store_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fold_en && last_ff) begin
         rsp_min_x     <= lo_in[0];
         rsp_max_x     <= hi_in[0];
         rsp_min_y     <= lo_in[1];
         rsp_max_y     <= hi_in[1];
         rsp_min_z     <= lo_in[2];
         rsp_max_z     <= hi_in[2];
         rsp_saturated <= clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         started_ff <= 1'b0;
         clip_ff    <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= cmd.fold_en && last_ff;
         if (cmd.store_en) begin
            wp_ff   <= wp_in;
            clip_ff <= clip_ff | (|clip_any);
         end
         if (cmd.fold_en) begin
            started_ff <= !last_ff;
            if (last_ff) begin
               clip_ff <= 1'b0;
            end
         end
      end
   end

endmodule

// ----- hw/rtl/transformed_vertex_bounding_box.sv -----
// Top level of the transformed vertex bounding box block.
// A vertex word (req_kind low) is transformed by the 3x4 matrix in the csr rows and
// stored; it is busy until the store is written; a new word is taken only when idle.
// Three multipliers, one per output axis, step over the four matrix columns one column
// a cycle, then the NORM state rounds, clips and writes the store. An index word
// (req_kind high) is busy for one registered store read and one min/max fold. The box
// of a run appears with rsp_valid for one cycle, registered after the store read and
// fold of the last index word; the receiver cannot stall it, so it must capture
// the word in that cycle. Indexes wrap modulo VERTEX_DEPTH; an entry never written
// reads as unknown data.
module transformed_vertex_bounding_box #(
   parameter int VERTEX_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_kind,
   input  logic signed [tvbb_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [tvbb_pkg::COORD_W-1:0]    req_coord_y,
   input  logic signed [tvbb_pkg::COORD_W-1:0]    req_coord_z,
   input  logic [tvbb_pkg::INDEX_W-1:0]           req_vertex_index,
   input  logic                                   req_last,
   input  logic                                   csr_write_enable,
   input  logic [tvbb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tvbb_pkg::ROW_W-1:0]             csr_write_data,
   output logic                                   rsp_valid,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_min_x,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_max_x,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_min_y,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_max_y,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_min_z,
   output logic signed [tvbb_pkg::COORD_W-1:0]    rsp_max_z,
   output logic                                   rsp_saturated
);
   import tvbb_pkg::*;

   cmd_type cmd;

   tvbb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .busy     (busy),
      .cmd      (cmd)
   );

   tvbb_dpath #(
      .VERTEX_DEPTH (VERTEX_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_vertex_index (req_vertex_index),
      .req_last         (req_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_min_x        (rsp_min_x),
      .rsp_max_x        (rsp_max_x),
      .rsp_min_y        (rsp_min_y),
      .rsp_max_y        (rsp_max_y),
      .rsp_min_z        (rsp_min_z),
      .rsp_max_z        (rsp_max_z),
      .rsp_saturated    (rsp_saturated)
   );

`ifndef SYNTHESIS
   // A result word only follows a fold, which runs while the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a preceding fold");

   // Each fold emits at most one word, and folds are never back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // The sequencer only leaves idle when a word is started.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");

   // Folds and stores never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.fold_en && cmd.store_en))
      else $error("store write and fold in the same cycle");
`endif

endmodule

// ----- bench/transformed_vertex_bounding_box_tb.sv -----
// Self-checking testbench for the transformed vertex bounding box block.
`timescale 1ns / 1ps

module transformed_vertex_bounding_box_tb;
   import tvbb_pkg::*;

   localparam int DEPTH          = 256;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct {
      logic                      kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [INDEX_W-1:0]        index;
      logic                      last;
   } req_word_type;

   typedef struct {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_z;
      logic                      saturated;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic [INDEX_W-1:0] req_vertex_index = '0;
   logic req_last = 1'b0;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ROW_W-1:0] csr_write_data = '0;
   logic rsp_valid;
   logic signed [COORD_W-1:0] rsp_min_x;
   logic signed [COORD_W-1:0] rsp_max_x;
   logic signed [COORD_W-1:0] rsp_min_y;
   logic signed [COORD_W-1:0] rsp_max_y;
   logic signed [COORD_W-1:0] rsp_min_z;
   logic signed [COORD_W-1:0] rsp_max_z;
   logic rsp_saturated;

   // Shadow copy of the block's configuration and state.
   logic [ROW_W-1:0] row_x = ROW_X_RESET;
   logic [ROW_W-1:0] row_y = ROW_Y_RESET;
   logic [ROW_W-1:0] row_z = ROW_Z_RESET;
   point_type vertex_mem [DEPTH];
   bit        slot_written [DEPTH];
   int        slots_filled = 0;
   int        write_slot = 0;
   point_type box_lo;
   point_type box_hi;
   bit        box_open = 1'b0;
   bit        clip_pending = 1'b0;

   box_type expected_boxes [$];

   bit idle_enable = 1'b1;
   int error_count = 0;
   int words_sent = 0;
   int boxes_checked = 0;
   int matrix_settings = 0;
   int quiet_cycles = 0;

   transformed_vertex_bounding_box #(
      .VERTEX_DEPTH(DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_vertex_index(req_vertex_index),
      .req_last        (req_last),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_min_x       (rsp_min_x),
      .rsp_max_x       (rsp_max_x),
      .rsp_min_y       (rsp_min_y),
      .rsp_max_y       (rsp_max_y),
      .rsp_min_z       (rsp_min_z),
      .rsp_max_z       (rsp_max_z),
      .rsp_saturated   (rsp_saturated)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // One row of the matrix applied to (x, y, z, 1), rounded half up and clipped to Q8.8.
   function automatic logic signed [COORD_W-1:0] transform_axis(
      input logic [ROW_W-1:0] row,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] z,
      inout bit clipped
   );
      longint acc;
      longint q;
      acc = longint'(x) * longint'($signed(row[15:0]))
          + longint'(y) * longint'($signed(row[31:16]))
          + longint'(z) * longint'($signed(row[47:32]))
          + longint'(ONE_Q8_8) * longint'($signed(row[63:48]));
      q = (acc + 2048) >>> FRAC_DROP;
      if (q > 32767) begin
         q = 32767;
         clipped = 1'b1;
      end
      if (q < -32768) begin
         q = -32768;
         clipped = 1'b1;
      end
      return q[COORD_W-1:0];
   endfunction

   task automatic predict_box(input req_word_type w);
      point_type p;
      bit        clip;
      box_type   b;
      if (w.kind == KIND_VERTEX) begin
         clip = clip_pending;
         p.x = transform_axis(row_x, w.x, w.y, w.z, clip);
         p.y = transform_axis(row_y, w.x, w.y, w.z, clip);
         p.z = transform_axis(row_z, w.x, w.y, w.z, clip);
         clip_pending = clip;
         vertex_mem[write_slot] = p;
         if (!slot_written[write_slot]) slots_filled++;
         slot_written[write_slot] = 1'b1;
         write_slot = w.last ? 0 : (write_slot + 1) % DEPTH;
      end else begin
         p = vertex_mem[w.index % DEPTH];
         if (!box_open) begin
            box_lo = p;
            box_hi = p;
            box_open = 1'b1;
         end else begin
            if (p.x < box_lo.x) box_lo.x = p.x;
            if (p.x > box_hi.x) box_hi.x = p.x;
            if (p.y < box_lo.y) box_lo.y = p.y;
            if (p.y > box_hi.y) box_hi.y = p.y;
            if (p.z < box_lo.z) box_lo.z = p.z;
            if (p.z > box_hi.z) box_hi.z = p.z;
         end
         if (w.last) begin
            b.min_x = box_lo.x;
            b.max_x = box_hi.x;
            b.min_y = box_lo.y;
            b.max_y = box_hi.y;
            b.min_z = box_lo.z;
            b.max_z = box_hi.z;
            b.saturated = clip_pending;
            expected_boxes.push_back(b);
            box_open = 1'b0;
            clip_pending = 1'b0;
         end
      end
   endtask

   // Leaves start high, bar a random pause, so the next word can follow without a gap.
   task automatic send_word(input req_word_type w);
      req_kind         <= w.kind;
      req_coord_x      <= w.x;
      req_coord_y      <= w.y;
      req_coord_z      <= w.z;
      req_vertex_index <= w.index;
      req_last         <= w.last;
      start            <= 1'b1;
      @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
      @(posedge clock);
      predict_box(w);
      words_sent++;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      int idx;
      do idx = $urandom_range(0, DEPTH - 1); while (!slot_written[idx]);
      return idx[INDEX_W-1:0];
   endfunction

   // Fields that a word's kind does not use still get random values.
   function automatic req_word_type make_word(input logic kind, input logic last);
      req_word_type w;
      w.kind  = kind;
      w.x     = rand_coord();
      w.y     = rand_coord();
      w.z     = rand_coord();
      w.index = (kind == KIND_INDEX) ? pick_index() : INDEX_W'($urandom);
      w.last  = last;
      return w;
   endfunction

   task automatic send_vertex(input int x, input int y, input int z, input logic last);
      req_word_type w;
      w = make_word(KIND_VERTEX, last);
      w.x = x[COORD_W-1:0];
      w.y = y[COORD_W-1:0];
      w.z = z[COORD_W-1:0];
      send_word(w);
   endtask

   task automatic send_index(input int idx, input logic last);
      req_word_type w;
      w = make_word(KIND_VERTEX, last);
      w.kind  = KIND_INDEX;
      w.index = idx[INDEX_W-1:0];
      send_word(w);
   endtask

   // Lowers start and waits until no box is outstanding and a vertex word has cleared.
   task automatic settle();
      start <= 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_matrix(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                             input logic [ROW_W-1:0] rz);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ROW_X;
      csr_write_data   <= rx;
      @(posedge clock);
      row_x = rx;
      csr_index        <= CSR_ROW_Y;
      csr_write_data   <= ry;
      @(posedge clock);
      row_y = ry;
      csr_index        <= CSR_ROW_Z;
      csr_write_data   <= rz;
      @(posedge clock);
      row_z = rz;
      csr_write_enable <= 1'b0;
      @(posedge clock);
      matrix_settings++;
   endtask

   // Each lane is a coefficient between -1.0 and +1.0 in Q4.12.
   function automatic logic [ROW_W-1:0] modest_row();
      logic [ROW_W-1:0] r;
      int v;
      for (int k = 0; k < LANES; k++) begin
         v = int'($urandom_range(0, 8192)) - 4096;
         r[16*k +: 16] = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] wild_row();
      return {$urandom, $urandom};
   endfunction

   task automatic test_identity_directed();
      send_vertex(0, 0, 0, 1'b0);
      send_vertex(32767, -32768, 1, 1'b0);
      // A last vertex sends the write pointer back to slot zero.
      send_vertex(-32768, 32767, -1, 1'b1);
      send_vertex(16'h1234, -16'h0567, 16'h0100, 1'b0);
      send_index(0, 1'b1);
      send_index(1, 1'b0);
      send_index(2, 1'b0);
      send_index(0, 1'b1);
      settle();
   endtask

   task automatic test_matrix_extremes();
      set_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
      send_vertex(32767, 32767, 32767, 1'b0);
      send_vertex(-32768, -32768, -32768, 1'b0);
      send_vertex(0, 0, 0, 1'b1);
      send_index(0, 1'b0);
      send_index(1, 1'b0);
      send_index(2, 1'b1);
      settle();
      set_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
      send_vertex(-32768, -32768, -32768, 1'b1);
      send_index(0, 1'b1);
      settle();
      set_matrix('0, '0, '0);
      send_vertex(32767, -32768, 12345, 1'b1);
      send_index(0, 1'b1);
      settle();
      // Constant terms of exactly +0.5, -0.5 and just under +0.5 LSB probe the rounding.
      set_matrix(64'h0008_0000_0000_1000, 64'hFFF8_0000_1000_0000,
                 64'h0007_1000_0000_0000);
      send_vertex(1, -1, 0, 1'b0);
      send_vertex(-1, 1, 2, 1'b1);
      send_index(1, 1'b0);
      send_index(0, 1'b1);
      settle();
   endtask

   // More vertices than the store holds, so the pointer wraps and overwrites.
   task automatic test_store_wrap();
      set_matrix(modest_row(), modest_row(), modest_row());
      for (int i = 0; i < DEPTH + 3; i++) send_word(make_word(KIND_VERTEX, i == DEPTH + 2));
      send_index(0, 1'b0);
      send_index(DEPTH - 1, 1'b1);
      for (int i = 0; i < 60; i++) send_word(make_word(KIND_INDEX, $urandom_range(0, 5) == 0));
      send_index(pick_index(), 1'b1);
      settle();
   endtask

   task automatic run_traffic(input int budget);
      int goal;
      int n;
      goal = words_sent + budget;
      while (words_sent < goal) begin
         case ($urandom_range(0, 9))
            8: begin
               // Vertices that leave the run open.
               n = $urandom_range(1, 5);
               for (int i = 0; i < n; i++) send_word(make_word(KIND_VERTEX, 1'b0));
            end
            9: begin
               // Indexes without a last word, so the box carries into the next run.
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++) send_word(make_word(KIND_INDEX, 1'b0));
            end
            default: begin
               n = $urandom_range(1, 16);
               for (int i = 0; i < n; i++) send_word(make_word(KIND_VERTEX, i == n - 1));
               n = $urandom_range(1, 12);
               for (int i = 0; i < n; i++) send_word(make_word(KIND_INDEX, i == n - 1));
            end
         endcase
      end
      // Close any open index run before the phase ends.
      send_word(make_word(KIND_INDEX, 1'b1));
      settle();
   endtask

   task automatic test_random_matrices();
      set_matrix(modest_row(), modest_row(), modest_row());
      run_traffic(120);
      set_matrix(wild_row(), wild_row(), wild_row());
      run_traffic(100);
      set_matrix(modest_row(), wild_row(), modest_row());
      run_traffic(100);
      set_matrix(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET);
      run_traffic(100);
      set_matrix(modest_row(), modest_row(), modest_row());
      run_traffic(100);
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      set_matrix(modest_row(), modest_row(), wild_row());
      run_traffic(150);
   endtask

   function automatic void check_field(input string name, input logic signed [16:0] want,
                                       input logic signed [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(negedge clock) begin : check_box
      box_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_boxes.size() == 0) begin
            $error("box word arrived with none expected");
            error_count++;
         end else begin
            want = expected_boxes.pop_front();
            check_field("min_x", 17'(want.min_x), 17'(rsp_min_x));
            check_field("max_x", 17'(want.max_x), 17'(rsp_max_x));
            check_field("min_y", 17'(want.min_y), 17'(rsp_min_y));
            check_field("max_y", 17'(want.max_y), 17'(rsp_max_y));
            check_field("min_z", 17'(want.min_z), 17'(rsp_min_z));
            check_field("max_z", 17'(want.max_z), 17'(rsp_max_z));
            check_field("saturated", 17'(want.saturated), 17'(rsp_saturated));
            boxes_checked++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("transformed_vertex_bounding_box_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_directed();
      test_matrix_extremes();
      test_store_wrap();
      test_random_matrices();
      test_back_to_back();
      settle();
      $display("Sent %0d request words and checked %0d boxes under %0d matrix settings.",
               words_sent, boxes_checked, matrix_settings);
      $display("Store wrap, clipping, rounding and back-to-back streaming were exercised.");
      if (error_count == 0 && expected_boxes.size() == 0) begin
         $display("transformed_vertex_bounding_box_tb: done, clean");
      end else begin
         if (expected_boxes.size() != 0)
            $error("%0d expected boxes never arrived", expected_boxes.size());
         $display("transformed_vertex_bounding_box_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/tvbb_pkg.sv
hw/rtl/tvbb_ctrl.sv
hw/rtl/tvbb_dpath.sv
hw/rtl/transformed_vertex_bounding_box.sv
bench/transformed_vertex_bounding_box_tb.sv
